@@ hdl/scd_pkg.sv @@
// Shared types and constants for the sector cache directory.
`timescale 1ns / 1ps

package scd_pkg;

   localparam int SecW       = 32;
   localparam int SlotW      = 6;
   localparam int OpW        = 2;
   localparam int MaxResults = 64;
   localparam int CntW       = 7;
   localparam int RspDataW   = 48;

   localparam logic [OpW-1:0] OP_READ  = 2'd0;
   localparam logic [OpW-1:0] OP_WRITE = 2'd1;
   localparam logic [OpW-1:0] OP_FLUSH = 2'd2;

   typedef struct packed {
      logic            valid;
      logic            dirty;
      logic            accessed;
      logic [SecW-1:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_HIT,
      WR_FILL,
      WR_AGE,
      WR_VICTIM,
      WR_CLEAN
   } wr_kind_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_HIT,
      OUT_FREE,
      OUT_VICTIM,
      OUT_PEND,
      OUT_PEND_LAST,
      OUT_EMPTY
   } out_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         scan_rd;
      logic         hand_rd;
      logic         pend_load;
      wr_kind_type  wr_kind;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic chk;
      logic ent_valid;
      logic ent_dirty;
      logic ent_acc;
      logic tag_hit;
      logic chk_last;
      logic idx_end;
      logic free_found;
      logic pend;
      logic nfl_full;
      logic out_free;
   } status_type;

endpackage

@@ hdl/scd_dpath.sv @@
// Datapath: slot directory memory, scan and clock hand counters, result register.
`timescale 1ns / 1ps

module scd_dpath #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [scd_pkg::SecW-1:0]      req_sector,
   input  logic [scd_pkg::OpW-1:0]       req_op,
   input  scd_pkg::cmd_type              cmd,
   output scd_pkg::status_type           status,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   // slot[5:0], hit[6], fill_needed[7], writeback[8], writeback_sector[40:9], zero pad
   output logic [scd_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);
   import scd_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   entry_type mem [ENTRIES];
   entry_type rdata_ff;
   entry_type wr_data;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   logic [AW:0]     idx_ff, idx_in;
   logic            idx_end;
   logic            chk_ff;
   logic [AW-1:0]   chk_idx_ff;
   logic            free_found_ff;
   logic [AW-1:0]   free_idx_ff;
   logic [AW-1:0]   hand_ff, hand_next;
   logic [CntW-1:0] nfl_ff;
   logic            pend_ff;
   logic [AW-1:0]   pend_idx_ff;
   logic [SecW-1:0] pend_tag_ff;
   logic [SecW-1:0] sec_ff;
   logic            write_ff;

   logic             rsp_valid_ff;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic             hit_ff, hit_in;
   logic             fill_ff, fill_in;
   logic             wb_ff, wb_in;
   logic [SecW-1:0]  wbsec_ff, wbsec_in;
   logic             last_ff, last_in;

   assign idx_end   = (idx_ff == (AW+1)'(ENTRIES));
   assign hand_next = (hand_ff == AW'(ENTRIES - 1)) ? '0 : hand_ff + 1'b1;

   assign rd_en   = (cmd.scan_rd && !idx_end) || cmd.hand_rd;
   assign rd_addr = cmd.hand_rd ? hand_ff : idx_ff[AW-1:0];

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff[AW-1:0];
      wr_data = '0;
      case (cmd.wr_kind)
         WR_CLEAR: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
         end
         WR_HIT: begin
            wr_addr = chk_idx_ff;
            wr_data = '{valid: 1'b1, dirty: rdata_ff.dirty | write_ff,
                        accessed: 1'b1, tag: rdata_ff.tag};
         end
         WR_FILL: begin
            wr_addr = free_idx_ff;
            wr_data = '{valid: 1'b1, dirty: write_ff, accessed: 1'b1, tag: sec_ff};
         end
         WR_AGE: begin
            wr_addr          = hand_ff;
            wr_data          = rdata_ff;
            wr_data.accessed = 1'b0;
         end
         WR_VICTIM: begin
            wr_addr = hand_ff;
            wr_data = '{valid: 1'b1, dirty: write_ff, accessed: 1'b1, tag: sec_ff};
         end
         WR_CLEAN: begin
            wr_addr       = chk_idx_ff;
            wr_data       = rdata_ff;
            wr_data.dirty = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if ((cmd.scan_rd && !idx_end) || cmd.wr_kind == WR_CLEAR) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         chk_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         hand_ff       <= '0;
         nfl_ff        <= '0;
         pend_ff       <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         chk_ff <= cmd.scan_rd && !idx_end;
         if (cmd.load_req) begin
            free_found_ff <= 1'b0;
            nfl_ff        <= '0;
            pend_ff       <= 1'b0;
         end else begin
            if (chk_ff && !rdata_ff.valid) begin
               free_found_ff <= 1'b1;
            end
            if (cmd.pend_load) begin
               pend_ff <= 1'b1;
               nfl_ff  <= nfl_ff + 1'b1;
            end
         end
         if (cmd.wr_kind == WR_AGE || cmd.wr_kind == WR_VICTIM) begin
            hand_ff <= hand_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sec_ff   <= req_sector;
         write_ff <= (req_op == OP_WRITE);
      end
      if (cmd.scan_rd && !idx_end) begin
         chk_idx_ff <= idx_ff[AW-1:0];
      end
      // only the lowest free slot is kept
      if (chk_ff && !rdata_ff.valid && !free_found_ff) begin
         free_idx_ff <= chk_idx_ff;
      end
      if (cmd.pend_load) begin
         pend_idx_ff <= chk_idx_ff;
         pend_tag_ff <= rdata_ff.tag;
      end
   end

   always_comb begin
      slot_in  = '0;
      hit_in   = 1'b0;
      fill_in  = 1'b0;
      wb_in    = 1'b0;
      wbsec_in = '0;
      last_in  = 1'b1;
      case (cmd.out_kind)
         OUT_HIT: begin
            slot_in = SlotW'(chk_idx_ff);
            hit_in  = 1'b1;
         end
         OUT_FREE: begin
            slot_in = SlotW'(free_idx_ff);
            fill_in = !write_ff;
         end
         OUT_VICTIM: begin
            slot_in  = SlotW'(hand_ff);
            fill_in  = !write_ff;
            wb_in    = rdata_ff.dirty;
            wbsec_in = rdata_ff.dirty ? rdata_ff.tag : '0;
         end
         OUT_PEND: begin
            slot_in  = SlotW'(pend_idx_ff);
            wb_in    = 1'b1;
            wbsec_in = pend_tag_ff;
            last_in  = 1'b0;
         end
         OUT_PEND_LAST: begin
            slot_in  = SlotW'(pend_idx_ff);
            wb_in    = 1'b1;
            wbsec_in = pend_tag_ff;
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_kind != OUT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_kind != OUT_NONE) begin
         slot_ff  <= slot_in;
         hit_ff   <= hit_in;
         fill_ff  <= fill_in;
         wb_ff    <= wb_in;
         wbsec_ff <= wbsec_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, wbsec_ff, wb_ff, fill_ff, hit_ff, slot_ff};
   assign rsp_tlast  = last_ff;

   assign status.chk        = chk_ff;
   assign status.ent_valid  = rdata_ff.valid;
   assign status.ent_dirty  = rdata_ff.dirty;
   assign status.ent_acc    = rdata_ff.accessed;
   assign status.tag_hit    = chk_ff && rdata_ff.valid && (rdata_ff.tag == sec_ff);
   assign status.chk_last   = (chk_idx_ff == AW'(ENTRIES - 1));
   assign status.idx_end    = idx_end;
   assign status.free_found = free_found_ff;
   assign status.pend       = pend_ff;
   assign status.nfl_full   = (nfl_ff == CntW'(MaxResults));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef SYNTH
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_kind != OUT_NONE) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while holding an untaken result");

   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= AW'(ENTRIES - 1))
      else $error("clock hand out of range");

   a_flush_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.pend_load |-> !status.nfl_full)
      else $error("flush reported more than the result cap");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hit_ff) |-> (!wb_ff && !fill_ff && last_ff))
      else $error("hit result carries a transfer");
`endif

endmodule

@@ hdl/scd_ctrl.sv @@
// Controller state machine: clearing pass, lookup scan, clock sweep and flush walk.
`timescale 1ns / 1ps

module scd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic [scd_pkg::OpW-1:0] req_op,
   output logic                    req_tready,
   input  scd_pkg::status_type     status,
   output scd_pkg::cmd_type        cmd
);
   import scd_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_LOOK   = 10'b0000000100,
      S_HIT    = 10'b0000001000,
      S_DECIDE = 10'b0000010000,
      S_SW_RD  = 10'b0000100000,
      S_SW_CHK = 10'b0001000000,
      S_F_RD   = 10'b0010000000,
      S_F_CHK  = 10'b0100000000,
      S_F_END  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '{load_req: 1'b0, scan_rd: 1'b0, hand_rd: 1'b0, pend_load: 1'b0,
                   wr_kind: WR_NONE, out_kind: OUT_NONE};
      case (state_ff)
         S_CLEAR: begin
            if (status.idx_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.wr_kind = WR_CLEAR;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               case (req_op)
                  OP_READ, OP_WRITE: state_in = S_LOOK;
                  OP_FLUSH:          state_in = S_F_RD;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_LOOK: begin
            // reads stream one slot a cycle; a hit stops the scan with its word held
            if (status.tag_hit) begin
               if (status.out_free) begin
                  cmd.wr_kind  = WR_HIT;
                  cmd.out_kind = OUT_HIT;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_HIT;
               end
            end else if (status.chk && status.chk_last) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         S_HIT: begin
            if (status.out_free) begin
               cmd.wr_kind  = WR_HIT;
               cmd.out_kind = OUT_HIT;
               state_in     = S_IDLE;
            end
         end
         S_DECIDE: begin
            if (!status.free_found) begin
               state_in = S_SW_RD;
            end else if (status.out_free) begin
               cmd.wr_kind  = WR_FILL;
               cmd.out_kind = OUT_FREE;
               state_in     = S_IDLE;
            end
         end
         S_SW_RD: begin
            cmd.hand_rd = 1'b1;
            state_in    = S_SW_CHK;
         end
         S_SW_CHK: begin
            if (status.ent_acc) begin
               cmd.wr_kind = WR_AGE;
               state_in    = S_SW_RD;
            end else if (status.out_free) begin
               cmd.wr_kind  = WR_VICTIM;
               cmd.out_kind = OUT_VICTIM;
               state_in     = S_IDLE;
            end
         end
         S_F_RD: begin
            if (status.idx_end || status.nfl_full) begin
               state_in = S_F_END;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_F_CHK;
            end
         end
         S_F_CHK: begin
            // one dirty slot is held back so the final one can carry last
            if (!(status.ent_valid && status.ent_dirty)) begin
               state_in = S_F_RD;
            end else if (!status.pend) begin
               cmd.pend_load = 1'b1;
               cmd.wr_kind   = WR_CLEAN;
               state_in      = S_F_RD;
            end else if (status.out_free) begin
               cmd.out_kind  = OUT_PEND;
               cmd.pend_load = 1'b1;
               cmd.wr_kind   = WR_CLEAN;
               state_in      = S_F_RD;
            end
         end
         S_F_END: begin
            if (status.out_free) begin
               cmd.out_kind = status.pend ? OUT_PEND_LAST : OUT_EMPTY;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/sector_cache_directory_clock.sv @@
// Top level of the sector cache directory with clock replacement.
// A hit answers once the tag scan reaches its slot, a miss with a free slot after the whole scan;
// a full directory adds a clock sweep, one read and check per step (up to ENTRIES+1 steps).
// Throughput: one request at a time; the single-port tag scan, one slot per cycle, sets it.
// Flush reads then checks each slot in turn and gives one result per dirty slot (at most 64), or one empty result.
// Reset: synchronous; then a clearing pass over every slot before the first request.
`timescale 1ns / 1ps

module sector_cache_directory_clock #(
   parameter int ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // sector[31:0]
   input  logic [scd_pkg::SecW-1:0]     req_tdata,
   // op[1:0]
   input  logic [scd_pkg::OpW-1:0]      req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // slot[5:0], hit[6], fill_needed[7], writeback[8], writeback_sector[40:9], zero pad
   output logic [scd_pkg::RspDataW-1:0] rsp_tdata,
   output logic                         rsp_tlast
);
   import scd_pkg::*;

   cmd_type    cmd;
   status_type status;

   scd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scd_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_sector (req_tdata),
      .req_op     (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sector cache directory with clock replacement.
`timescale 1ns / 1ps

module tb_top;
   import scd_pkg::*;

   localparam int                 SLOTS       = 64;
   localparam logic [OpW-1:0]     OP_UNUSED   = 2'd3;
   // worst case: full-directory miss, sweep of every slot, plus stalls
   localparam int                 TAIL_CYCLES = 400;
   localparam int                 IDLE_LIMIT  = 2000;

   typedef struct {
      logic [SlotW-1:0] slot;
      logic             hit;
      logic             fill_needed;
      logic             writeback;
      logic [SecW-1:0]  writeback_sector;
      logic             last;
   } slot_report_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SecW-1:0]     req_tdata  = '0;
   logic [OpW-1:0]      req_tuser  = OP_READ;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;

   // directory mirror
   bit                  slot_valid [SLOTS];
   bit                  slot_dirty [SLOTS];
   bit                  slot_used  [SLOTS];
   logic [SecW-1:0]     slot_sector[SLOTS];
   logic [SlotW-1:0]    hand;

   slot_report_type     slot_reports_q[$];
   int                  error_count = 0;
   int                  burst_left  = 0;
   int                  idle_run    = 0;
   int                  ready_mode  = 0;
   int                  mode_left   = 0;

   always #1 clock = ~clock;

   sector_cache_directory_clock #(.ENTRIES(SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic void push_report(logic [SlotW-1:0] slot, logic hit, logic fill,
                                       logic wb, logic [SecW-1:0] wb_sector, logic last);
      slot_report_type r;
      r.slot             = slot;
      r.hit              = hit;
      r.fill_needed      = fill;
      r.writeback        = wb;
      r.writeback_sector = wb_sector;
      r.last             = last;
      slot_reports_q.push_back(r);
   endfunction

   function automatic void update_directory(logic [OpW-1:0] op, logic [SecW-1:0] sector);
      int               i;
      int               n;
      int               k;
      bit               found;
      bit               is_write;
      logic [SlotW-1:0] s;
      logic [SlotW-1:0] h;
      if (op == OP_UNUSED) return;
      if (op == OP_FLUSH) begin
         n = 0;
         for (i = 0; i < SLOTS; i++) if (slot_valid[i] && slot_dirty[i]) n++;
         if (n == 0) begin
            push_report('0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
            return;
         end
         k = 0;
         for (i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_dirty[i]) begin
               push_report(SlotW'(i), 1'b0, 1'b0, 1'b1, slot_sector[i], k == n - 1);
               slot_dirty[i] = 1'b0;
               k++;
            end
         end
         return;
      end
      is_write = (op == OP_WRITE);
      found = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (!found && slot_valid[i] && slot_sector[i] == sector) begin
            found = 1'b1;
            slot_used[i] = 1'b1;
            if (is_write) slot_dirty[i] = 1'b1;
            push_report(SlotW'(i), 1'b1, 1'b0, 1'b0, '0, 1'b1);
         end
      end
      if (found) return;
      found = 1'b0;
      s = '0;
      for (i = 0; i < SLOTS; i++) begin
         if (!found && !slot_valid[i]) begin
            found = 1'b1;
            s = SlotW'(i);
         end
      end
      if (found) begin
         push_report(s, 1'b0, !is_write, 1'b0, '0, 1'b1);
      end else begin
         // clock sweep: age accessed slots until one with a clear bit turns up
         h = hand;
         found = 1'b0;
         for (i = 0; i <= SLOTS; i++) begin
            if (!found) begin
               if (!slot_used[h]) found = 1'b1;
               else begin
                  slot_used[h] = 1'b0;
                  h = h + 1'b1;
               end
            end
         end
         hand = h + 1'b1;
         s = h;
         if (slot_dirty[s]) push_report(s, 1'b0, !is_write, 1'b1, slot_sector[s], 1'b1);
         else push_report(s, 1'b0, !is_write, 1'b0, '0, 1'b1);
      end
      slot_valid[s]  = 1'b1;
      slot_sector[s] = sector;
      slot_dirty[s]  = is_write;
      slot_used[s]   = 1'b1;
   endfunction

   task automatic send_request(input logic [OpW-1:0] op, input logic [SecW-1:0] sector);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= sector;
      do @(posedge clock); while (!req_tready);
      update_directory(op, sector);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 7);
      end
   endtask

   // hold the request side off until every predicted report has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (slot_reports_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_flush();
      send_request(OP_FLUSH, 32'h0000_0000);
      send_request(OP_FLUSH, 32'hFFFF_FFFF);
   endtask

   task automatic test_hit_miss();
      send_request(OP_READ,  32'h0000_0000);
      send_request(OP_READ,  32'h0000_0000);
      send_request(OP_WRITE, 32'h0000_0000);
      send_request(OP_WRITE, 32'hFFFF_FFFF);
      send_request(OP_READ,  32'hFFFF_FFFF);
      send_request(OP_WRITE, 32'h5555_5555);
      send_request(OP_READ,  32'hAAAA_AAAA);
      send_request(OP_WRITE, 32'hAAAA_AAAA);
   endtask

   task automatic test_flush();
      wait_drained();
      send_request(OP_FLUSH, 32'h1234_5678);
      send_request(OP_FLUSH, 32'h0000_0000);
   endtask

   task automatic test_unused_op();
      send_request(OP_UNUSED, 32'h0000_0000);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_READ,   32'h0000_0000);
      send_request(OP_READ,   32'hFFFF_FFFF);
   endtask

   // fill every slot with fresh sectors, then force sweeps and a large flush
   task automatic test_fill_and_evict();
      logic [SecW-1:0] base;
      int              i;
      base = $urandom;
      for (i = 0; i < SLOTS; i++)
         send_request($urandom_range(0, 1) ? OP_WRITE : OP_READ, base + i);
      for (i = 0; i < 24; i++) begin
         if ($urandom_range(0, 1))
            send_request($urandom_range(0, 1) ? OP_WRITE : OP_READ, base + SLOTS + i);
         else
            send_request($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                         base + $urandom_range(0, SLOTS - 1));
      end
      wait_drained();
      send_request(OP_FLUSH, $urandom);
   endtask

   task automatic test_random_mix();
      logic [SecW-1:0] base;
      int              span;
      int              i;
      int              pick;
      base = '0;
      span = 8;
      for (i = 0; i < 150; i++) begin
         if (i % 30 == 0) begin
            base = $urandom;
            case ($urandom_range(0, 2))
               0: span = 8;
               1: span = 72;
               default: span = 120;
            endcase
         end
         if ($urandom_range(0, 29) == 0) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 40)      send_request(OP_READ,  base + $urandom_range(0, span - 1));
         else if (pick < 80) send_request(OP_WRITE, base + $urandom_range(0, span - 1));
         else if (pick < 88) send_request(OP_FLUSH, $urandom);
         else if (pick < 92) send_request(OP_UNUSED, $urandom);
         else                send_request($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom);
      end
   endtask

   // receiver: always ready, random, or ready with a one-in-four chance, switching now and then
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 100);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      slot_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (slot_reports_q.size() == 0) begin
            $error("unexpected response: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = slot_reports_q.pop_front();
            if (rsp_tdata[5:0] !== want.slot) begin
               $error("slot mismatch: expected %0d, actual %0d", want.slot, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[6] !== want.hit) begin
               $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_tdata[6]);
               error_count++;
            end
            if (rsp_tdata[7] !== want.fill_needed) begin
               $error("fill_needed mismatch: expected %0d, actual %0d",
                      want.fill_needed, rsp_tdata[7]);
               error_count++;
            end
            if (rsp_tdata[8] !== want.writeback) begin
               $error("writeback mismatch: expected %0d, actual %0d",
                      want.writeback, rsp_tdata[8]);
               error_count++;
            end
            if (rsp_tdata[40:9] !== want.writeback_sector) begin
               $error("writeback_sector mismatch: expected %h, actual %h",
                      want.writeback_sector, rsp_tdata[40:9]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      hand = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i]  = 1'b0;
         slot_dirty[i]  = 1'b0;
         slot_used[i]   = 1'b0;
         slot_sector[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_flush();
      test_hit_miss();
      test_flush();
      test_unused_op();
      test_fill_and_evict();
      test_random_mix();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && slot_reports_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/scd_pkg.sv
hdl/scd_dpath.sv
hdl/scd_ctrl.sv
hdl/sector_cache_directory_clock.sv
tb/tb_top.sv
